// ----- src/cde_pkg.sv -----
// ----------------------------------------------------------------------------
// Circular deque package
// Shared widths, sizes and command codes of the circular deque unit.
// ----------------------------------------------------------------------------
package cde_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd4;

endpackage

// ----- src/cde_ifs.sv -----
// ----------------------------------------------------------------------------
// Circular deque channels
// Valid/ready channels for commands, results and the capacity register.
// ----------------------------------------------------------------------------
interface cde_req_if;
  logic                              valid;
  logic                              ready;
  logic [cde_pkg::CMD_W-1:0]         cmd;
  logic signed [cde_pkg::DATA_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface cde_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [cde_pkg::DATA_W-1:0] front_value;
  logic signed [cde_pkg::DATA_W-1:0] rear_value;
  logic                              is_empty;
  logic                              is_full;
  logic [cde_pkg::CNT_W-1:0]         occupancy;

  modport source (output valid, ok, front_value, rear_value, is_empty, is_full, occupancy,
                  input ready);
  modport sink   (input valid, ok, front_value, rear_value, is_empty, is_full, occupancy,
                  output ready);
endinterface

interface cde_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [cde_pkg::CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- src/circular_deque_unit.sv -----
// ----------------------------------------------------------------------------
// Circular deque unit
// Bounded double-ended queue of 32-bit words kept in a ring of RAM entries.
// Each word goes through update and write, then read, then the result register.
// No new word is taken until the last word's result has been registered.
// Reset empties the deque and sets the capacity to 64; no clearing pass runs.
// A capacity write empties the deque in the cycle it is taken.
// ----------------------------------------------------------------------------
module circular_deque_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  cde_req_if.sink   req_i,
  cde_rsp_if.source rsp_o,
  cde_cfg_if.sink   cfg_i
);

  import cde_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cap_q, cap_d;
  logic [PTR_W-1:0]  front_q, front_d;
  logic [PTR_W-1:0]  rear_q, rear_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ok_q, ok_d;
  logic              we;
  logic [PTR_W-1:0]  waddr;
  logic [DATA_W-1:0] front_rdata;
  logic [DATA_W-1:0] rear_rdata;
  logic              accept;
  logic              load_out;
  logic              out_valid_q;
  logic              out_ok_q;
  logic [DATA_W-1:0] out_front_q;
  logic [DATA_W-1:0] out_rear_q;
  logic              out_empty_q;
  logic              out_full_q;
  logic [CNT_W-1:0]  out_count_q;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(p) + CNT_W'(1);
    return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(logic [PTR_W-1:0] p, logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] last;
    last = cap - CNT_W'(1);
    return (p == '0 || CNT_W'(p) >= cap) ? last[PTR_W-1:0] : p - PTR_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cap(logic [CNT_W-1:0] v);
    if (v == '0) begin
      return CNT_W'(1);
    end
    return (v > CAP_RESET) ? CAP_RESET : v;
  endfunction

  assign req_i.ready = (state_q == ST_IDLE) && !cfg_i.valid;
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign load_out    = (state_q == ST_RESP) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    cap_d   = cap_q;
    front_d = front_q;
    rear_d  = rear_q;
    count_d = count_q;
    ok_d    = ok_q;
    we      = 1'b0;
    waddr   = front_q;
    if (cfg_i.valid && cfg_i.ready) begin
      cap_d   = clamp_cap(cfg_i.data);
      front_d = '0;
      rear_d  = PTR_W'(cap_d - CNT_W'(1));
      count_d = '0;
    end else if (accept) begin
      ok_d = 1'b0;
      case (req_i.cmd)
        CMD_INS_FRONT: begin
          if (count_q < cap_q) begin
            front_d = ptr_dec(front_q, cap_q);
            waddr   = front_d;
            we      = 1'b1;
            count_d = count_q + CNT_W'(1);
            ok_d    = 1'b1;
          end
        end
        CMD_INS_REAR: begin
          if (count_q < cap_q) begin
            rear_d  = ptr_inc(rear_q, cap_q);
            waddr   = rear_d;
            we      = 1'b1;
            count_d = count_q + CNT_W'(1);
            ok_d    = 1'b1;
          end
        end
        CMD_DEL_FRONT: begin
          if (count_q != '0) begin
            front_d = ptr_inc(front_q, cap_q);
            count_d = count_q - CNT_W'(1);
            ok_d    = 1'b1;
          end
        end
        CMD_DEL_REAR: begin
          if (count_q != '0) begin
            rear_d  = ptr_dec(rear_q, cap_q);
            count_d = count_q - CNT_W'(1);
            ok_d    = 1'b1;
          end
        end
        CMD_PEEK: begin
          ok_d = (count_q != '0);
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      front_q     <= '0;
      rear_q      <= PTR_W'(CAP_RESET - CNT_W'(1));
      count_q     <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_ok_q    <= ok_q;
      out_front_q <= (count_q == '0) ? '1 : front_rdata;
      out_rear_q  <= (count_q == '0) ? '1 : rear_rdata;
      out_empty_q <= (count_q == '0);
      out_full_q  <= (count_q == cap_q);
      out_count_q <= count_q;
    end
  end

  cde_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .re_i    (state_q == ST_READ),
    .raddr_i (front_q),
    .rdata_o (front_rdata)
  );

  cde_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_rear_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.value),
    .re_i    (state_q == ST_READ),
    .raddr_i (rear_q),
    .rdata_o (rear_rdata)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ok          = out_ok_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.rear_value  = out_rear_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.is_full     = out_full_q;
  assign rsp_o.occupancy   = out_count_q;

endmodule

// ----- src/cde_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module cde_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- verif/tb_circular_deque_unit.sv -----
// ----------------------------------------------------------------------------
// Circular deque unit testbench
// Drives insert, delete, peek and unused commands plus capacity writes through
// the valid/ready channels, predicts each result word from a table of outcomes
// or a behavioral mirror of the deque, and checks every field as it arrives.
// ----------------------------------------------------------------------------
module tb_circular_deque_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import cde_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
  localparam int unsigned      CYCLE_LIMIT = 200000;
  localparam int unsigned      HOLD_CYCLES = 80;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
    logic              is_empty;
    logic              is_full;
    logic [CNT_W-1:0]  occupancy;
  } deque_result_t;

  typedef enum logic {ROW_WORD, ROW_CAP} row_kind_e;
  typedef enum logic [1:0] {PACE_FLAT, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_e;
  typedef enum logic [1:0] {MIX_EVEN, MIX_FILL, MIX_DRAIN, MIX_SWING} mix_e;

  typedef struct {
    row_kind_e         kind;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;
    bit                typed;
    deque_result_t     want;
  } stim_row_t;

  typedef struct {
    logic [CNT_W-1:0] cap;
    pace_e            pace;
    mix_e             mix;
    int               words;
    bit               hold;
    bit               pause;
  } phase_t;

  localparam deque_result_t EMPTY_OUT = '{1'b0, '1, '1, 1'b1, 1'b0, '0};
  localparam deque_result_t NO_WANT   = '0;

  logic clk_i;
  logic rst_ni;

  cde_req_if req_bus ();
  cde_rsp_if rsp_bus ();
  cde_cfg_if cfg_bus ();

  circular_deque_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  logic [DATA_W-1:0] ring_mirror [DEPTH];
  logic [CNT_W-1:0]  mirror_cap;
  logic [PTR_W-1:0]  mirror_front;
  logic [PTR_W-1:0]  mirror_rear;
  logic [CNT_W-1:0]  mirror_count;

  deque_result_t pending_results [$];
  deque_result_t row_want;
  bit            row_typed;
  int unsigned   words_sent;
  int unsigned   results_seen;
  int unsigned   err_count;
  int unsigned   req_idle_pct;
  int unsigned   rsp_stall_pct;
  bit            rsp_hold_req;
  int unsigned   cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic deque_result_t outcome(bit ok, logic [DATA_W-1:0] f, logic [DATA_W-1:0] r,
                                            bit e, bit fu, int occ);
    outcome = '{ok, f, r, e, fu, CNT_W'(occ)};
  endfunction

  function automatic void set_capacity(logic [CNT_W-1:0] d);
    if (d == 0) begin
      mirror_cap = CNT_W'(1);
    end else if (d > DEPTH) begin
      mirror_cap = CNT_W'(DEPTH);
    end else begin
      mirror_cap = d;
    end
    mirror_front = '0;
    mirror_rear  = PTR_W'(mirror_cap - 1);
    mirror_count = '0;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_fwd(logic [PTR_W-1:0] p);
    return (int'(p) + 1 >= int'(mirror_cap)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_back(logic [PTR_W-1:0] p);
    return (p == 0 || int'(p) >= int'(mirror_cap)) ? PTR_W'(mirror_cap - 1) : p - 1'b1;
  endfunction

  function automatic deque_result_t deque_apply(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v);
    deque_result_t r;
    r = '0;
    case (c)
      CMD_INS_FRONT: begin
        if (mirror_count < mirror_cap) begin
          mirror_front = ptr_back(mirror_front);
          ring_mirror[mirror_front] = v;
          mirror_count++;
          r.ok = 1'b1;
        end
      end
      CMD_INS_REAR: begin
        if (mirror_count < mirror_cap) begin
          mirror_rear = ptr_fwd(mirror_rear);
          ring_mirror[mirror_rear] = v;
          mirror_count++;
          r.ok = 1'b1;
        end
      end
      CMD_DEL_FRONT: begin
        if (mirror_count != 0) begin
          mirror_front = ptr_fwd(mirror_front);
          mirror_count--;
          r.ok = 1'b1;
        end
      end
      CMD_DEL_REAR: begin
        if (mirror_count != 0) begin
          mirror_rear = ptr_back(mirror_rear);
          mirror_count--;
          r.ok = 1'b1;
        end
      end
      CMD_PEEK: r.ok = (mirror_count != 0);
      default: r.ok = 1'b0;
    endcase
    r.is_empty    = (mirror_count == 0);
    r.front_value = r.is_empty ? '1 : ring_mirror[mirror_front];
    r.rear_value  = r.is_empty ? '1 : ring_mirror[mirror_rear];
    r.is_full     = (mirror_count == mirror_cap);
    r.occupancy   = mirror_count;
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(mix_e m);
    int unsigned roll;
    int unsigned lim [5];
    roll = $urandom_range(0, 99);
    case (m)
      MIX_FILL:  lim = '{40, 75, 80, 85, 95};
      MIX_DRAIN: lim = '{10, 20, 50, 80, 92};
      default:   lim = '{22, 44, 64, 84, 94};
    endcase
    if (roll < lim[0]) return CMD_INS_FRONT;
    if (roll < lim[1]) return CMD_INS_REAR;
    if (roll < lim[2]) return CMD_DEL_FRONT;
    if (roll < lim[3]) return CMD_DEL_REAR;
    if (roll < lim[4]) return CMD_PEEK;
    return CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    deque_result_t predicted;
    deque_result_t want;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        set_capacity(cfg_bus.data);
      end
      if (req_bus.valid && req_bus.ready) begin
        predicted = deque_apply(req_bus.cmd, req_bus.value);
        pending_results.push_back(row_typed ? row_want : predicted);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result word with no expectation waiting");
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("ok", want.ok, rsp_bus.ok);
          check_field("front_value", want.front_value, rsp_bus.front_value);
          check_field("rear_value", want.rear_value, rsp_bus.rear_value);
          check_field("is_empty", want.is_empty, rsp_bus.is_empty);
          check_field("is_full", want.is_full, rsp_bus.is_full);
          check_field("occupancy", want.occupancy, rsp_bus.occupancy);
        end
      end
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_word(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v, bit typed,
                           deque_result_t want);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.cmd   <= c;
    req_bus.value <= v;
    row_typed     <= typed;
    row_want      <= want;
    do @(posedge clk_i); while (!req_bus.ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (results_seen < words_sent);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] cap);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= cap;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    stim_row_t         rows [$];
    phase_t            phases [$];
    phase_t            ph;
    mix_e              m;
    logic [DATA_W-1:0] v;
    rst_ni        = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.cmd   = CMD_PEEK;
    req_bus.value = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = CAP_RESET;
    row_typed     = 1'b0;
    row_want      = '0;
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    rsp_hold_req  = 1'b0;
    words_sent    = 0;
    results_seen  = 0;
    err_count     = 0;
    foreach (ring_mirror[i]) ring_mirror[i] = '0;
    set_capacity(CAP_RESET);

    rows.push_back('{ROW_WORD, CMD_PEEK, 32'h0, 1'b1, EMPTY_OUT});
    rows.push_back('{ROW_WORD, CMD_DEL_FRONT, 32'hFFFFFFFF, 1'b1, EMPTY_OUT});
    rows.push_back('{ROW_WORD, CMD_DEL_REAR, 32'h0, 1'b1, EMPTY_OUT});
    rows.push_back('{ROW_WORD, CMD_RSVD5, 32'h5A5A5A5A, 1'b1, EMPTY_OUT});
    rows.push_back('{ROW_WORD, CMD_INS_FRONT, 32'h7FFFFFFF, 1'b1,
                     outcome(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1)});
    rows.push_back('{ROW_WORD, CMD_INS_REAR, 32'h80000000, 1'b1,
                     outcome(1, 32'h7FFFFFFF, 32'h80000000, 0, 0, 2)});
    rows.push_back('{ROW_WORD, CMD_INS_FRONT, 32'hFFFFFFFF, 1'b1,
                     outcome(1, 32'hFFFFFFFF, 32'h80000000, 0, 0, 3)});
    rows.push_back('{ROW_WORD, CMD_PEEK, 32'h0, 1'b1,
                     outcome(1, 32'hFFFFFFFF, 32'h80000000, 0, 0, 3)});
    rows.push_back('{ROW_WORD, CMD_RSVD7, 32'h12345678, 1'b1,
                     outcome(0, 32'hFFFFFFFF, 32'h80000000, 0, 0, 3)});
    rows.push_back('{ROW_WORD, CMD_DEL_REAR, 32'h0, 1'b1,
                     outcome(1, 32'hFFFFFFFF, 32'h7FFFFFFF, 0, 0, 2)});
    rows.push_back('{ROW_WORD, CMD_DEL_FRONT, 32'h0, 1'b1,
                     outcome(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1)});
    rows.push_back('{ROW_WORD, CMD_RSVD6, 32'hFFFFFFFF, 1'b1,
                     outcome(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 1)});
    rows.push_back('{ROW_WORD, CMD_DEL_FRONT, 32'h0, 1'b1,
                     outcome(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 0)});
    rows.push_back('{ROW_CAP, CMD_PEEK, 32'h0, 1'b0, NO_WANT});
    rows.push_back('{ROW_WORD, CMD_INS_REAR, 32'h0, 1'b1, outcome(1, 32'h0, 32'h0, 0, 1, 1)});
    rows.push_back('{ROW_WORD, CMD_INS_FRONT, 32'h55555555, 1'b1,
                     outcome(0, 32'h0, 32'h0, 0, 1, 1)});
    rows.push_back('{ROW_WORD, CMD_INS_REAR, 32'hAAAAAAAA, 1'b1,
                     outcome(0, 32'h0, 32'h0, 0, 1, 1)});
    rows.push_back('{ROW_WORD, CMD_DEL_REAR, 32'h0, 1'b1,
                     outcome(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 0)});
    rows.push_back('{ROW_WORD, CMD_INS_FRONT, 32'hAAAAAAAA, 1'b1,
                     outcome(1, 32'hAAAAAAAA, 32'hAAAAAAAA, 0, 1, 1)});
    rows.push_back('{ROW_WORD, CMD_PEEK, 32'h0, 1'b1,
                     outcome(1, 32'hAAAAAAAA, 32'hAAAAAAAA, 0, 1, 1)});
    rows.push_back('{ROW_WORD, CMD_DEL_FRONT, 32'h0, 1'b1,
                     outcome(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0, 0)});
    rows.push_back('{ROW_CAP, CMD_PEEK, 32'h7F, 1'b0, NO_WANT});
    rows.push_back('{ROW_WORD, CMD_INS_REAR, 32'h1, 1'b0, NO_WANT});
    rows.push_back('{ROW_WORD, CMD_INS_FRONT, 32'h2, 1'b0, NO_WANT});
    rows.push_back('{ROW_WORD, CMD_DEL_REAR, 32'h0, 1'b0, NO_WANT});

    phases.push_back('{7'd64,  PACE_FLAT,      MIX_FILL,  140, 1'b1, 1'b0});
    phases.push_back('{7'd2,   PACE_SRC_IDLE,  MIX_EVEN,   90, 1'b0, 1'b1});
    phases.push_back('{7'd3,   PACE_SNK_STALL, MIX_EVEN,   90, 1'b0, 1'b0});
    phases.push_back('{7'd1,   PACE_BOTH,      MIX_EVEN,   60, 1'b0, 1'b0});
    phases.push_back('{7'd100, PACE_BOTH,      MIX_SWING, 180, 1'b0, 1'b1});
    phases.push_back('{7'd17,  PACE_SNK_STALL, MIX_SWING, 100, 1'b0, 1'b0});
    phases.push_back('{7'd5,   PACE_FLAT,      MIX_EVEN,   70, 1'b1, 1'b0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CAP) begin
        write_capacity(rows[i].value[CNT_W-1:0]);
      end else begin
        send_word(rows[i].cmd, rows[i].value, rows[i].typed, rows[i].want);
      end
    end

    foreach (phases[p]) begin
      ph = phases[p];
      write_capacity(ph.cap);
      case (ph.pace)
        PACE_SRC_IDLE:  begin req_idle_pct = 61; rsp_stall_pct = 0;  end
        PACE_SNK_STALL: begin req_idle_pct = 0;  rsp_stall_pct = 61; end
        PACE_BOTH:      begin req_idle_pct = 11; rsp_stall_pct = 11; end
        default:        begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
      endcase
      for (int i = 0; i < ph.words; i++) begin
        if (ph.hold && i == ph.words / 3) rsp_hold_req = 1'b1;
        if (ph.pause && i == ph.words / 2) wait_drained();
        if (ph.mix == MIX_SWING) begin
          m = (i < ph.words / 2) ? MIX_FILL : MIX_DRAIN;
        end else begin
          m = ph.mix;
        end
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       v = 32'h80000000;
            1:       v = 32'h7FFFFFFF;
            2:       v = 32'h00000000;
            default: v = 32'hFFFFFFFF;
          endcase
        end else begin
          v = $urandom;
        end
        send_word(pick_cmd(m), v, 1'b0, NO_WANT);
      end
    end

    wait_drained();
    repeat (12) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/cde_pkg.sv
src/cde_ifs.sv
src/cde_ram.sv
src/circular_deque_unit.sv
verif/tb_circular_deque_unit.sv
